// ----- design/sip_pkg.sv -----
// ---------------------------------------------------------------------------
// Segment intersection package
// Shared widths, codes and the divider transaction type for the segment
// intersection pipeline.
// ---------------------------------------------------------------------------
package sip_pkg;

    // Field widths of the streaming interface.
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int HIT_BITS   = 24;

    // Derived arithmetic widths.
    localparam int DIFF_W  = COORD_BITS + 1;          // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;              // one cross term
    localparam int CROSS_W = PROD_W + 1;              // den, s_num, t_num
    localparam int MAG_W   = CROSS_W - 1;             // |den|, |t_num|
    localparam int NUM_W   = MAG_W + DIFF_W;          // |t_num| * |delta|

    // Quotient bits kept; anything at or above 2^QB_W always saturates.
    localparam int QB_W = ((HIT_BITS > COORD_BITS + FRAC_BITS) ?
                           HIT_BITS : COORD_BITS + FRAC_BITS) + 1;
    localparam int RA_W = NUM_W + FRAC_BITS + 2;
    localparam int RB_W = MAG_W + 1 + QB_W;
    localparam int REM_W = ((RA_W > RB_W) ? RA_W : RB_W) + 1;
    localparam int DIV_W = MAG_W + 1;                 // 2*|den|
    localparam int SUM_W = QB_W + 2;                  // signed result sum

    // Mode codes.
    localparam logic [1:0] MODE_SEG    = 2'd0;
    localparam logic [1:0] MODE_SHARED = 2'd1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_PARALLEL = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_SHARED   = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One transaction inside the divider pipeline.
    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [DIV_W-1:0] dvs;
        logic [QB_W:0]    quo_x;
        logic [QB_W:0]    quo_y;
        logic             neg_x;
        logic             neg_y;
        coord_t           base_x;
        coord_t           base_y;
        status_t          status;
    } div_t;

endpackage

// ----- design/segment_intersection_point.sv -----
// ---------------------------------------------------------------------------
// Segment intersection point
// Intersects two 2D segments or lines and reports the crossing point in
// fixed point, with segment bounds tests and saturation.
// ---------------------------------------------------------------------------
// Pipeline: 6 front stages, QB_W+1 divider stages (26 at default widths) and
// one output register between input transaction and result.
// Throughput: one transaction per cycle absent output stalls; each stage
// holds its own valid bit and loads whenever it is empty or its content
// moves on. Reset: synchronous active-low aresetn clears all valid bits;
// there is no other state.
module segment_intersection_point (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // first_start_x, first_start_y, first_end_x,
                                   // first_end_y, second_start_x, second_start_y,
                                   // second_end_x, second_end_y (16 bits each)
    input  logic [1:0]   s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // hit_x (24), hit_y (24)
    output logic [3:0]   m_tuser   // hit (1), status (3)
);
    import sip_pkg::*;

    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam sum_t HI_LIM = sum_t'((64'sd1 <<< (HIT_BITS - 1)) - 64'sd1);
    localparam sum_t LO_LIM = sum_t'(-(64'sd1 <<< (HIT_BITS - 1)));

    // Stage payloads.
    typedef struct packed {
        logic [1:0] mode;
        logic       shared;
        coord_t     p0x, p0y;
        diff_t      s1x, s1y, s2x, s2y, dx, dy;
    } st1_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       shared;
        coord_t     p0x, p0y;
        diff_t      s1x, s1y;
        prod_t      a, b, c, d, e, f;
    } st2_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       shared;
        coord_t     p0x, p0y;
        diff_t      s1x, s1y;
        cross_t     den, snum, tnum;
    } st3_t;

    typedef struct packed {
        status_t            status;
        coord_t             p0x, p0y;
        logic               neg_x, neg_y;
        logic [MAG_W-1:0]   ud, tmag;
        logic [DIFF_W-1:0]  mx, my;
    } st4_t;

    typedef struct packed {
        status_t            status;
        coord_t             p0x, p0y;
        logic               neg_x, neg_y;
        logic [MAG_W-1:0]   ud;
        logic [NUM_W-1:0]   nx, ny;
    } st5_t;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    div_t st6_reg, st6_next;
    logic [6:1] v_reg;
    logic [7:1] rdy;

    logic  div_ready, div_valid, out_ready;
    div_t  div_out;

    coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;

    assign p0x = s_tdata[15:0];
    assign p0y = s_tdata[31:16];
    assign p1x = s_tdata[47:32];
    assign p1y = s_tdata[63:48];
    assign p2x = s_tdata[79:64];
    assign p2y = s_tdata[95:80];
    assign p3x = s_tdata[111:96];
    assign p3y = s_tdata[127:112];

    // Stage 1: edge vectors and the shared endpoint check.
    always_comb begin
        st1_next.mode   = s_tuser;
        st1_next.p0x    = p0x;
        st1_next.p0y    = p0y;
        st1_next.s1x    = DIFF_W'(p1x) - DIFF_W'(p0x);
        st1_next.s1y    = DIFF_W'(p1y) - DIFF_W'(p0y);
        st1_next.s2x    = DIFF_W'(p3x) - DIFF_W'(p2x);
        st1_next.s2y    = DIFF_W'(p3y) - DIFF_W'(p2y);
        st1_next.dx     = DIFF_W'(p0x) - DIFF_W'(p2x);
        st1_next.dy     = DIFF_W'(p0y) - DIFF_W'(p2y);
        st1_next.shared = (s_tuser == MODE_SHARED) &&
                          ((p0x == p2x && p0y == p2y) || (p1x == p3x && p1y == p3y) ||
                           (p0x == p3x && p0y == p3y) || (p2x == p1x && p2y == p1y));
    end

    // Stage 2: the six cross-product terms.
    always_comb begin
        st2_next.mode   = st1_reg.mode;
        st2_next.shared = st1_reg.shared;
        st2_next.p0x    = st1_reg.p0x;
        st2_next.p0y    = st1_reg.p0y;
        st2_next.s1x    = st1_reg.s1x;
        st2_next.s1y    = st1_reg.s1y;
        st2_next.a = PROD_W'(st1_reg.s1x) * PROD_W'(st1_reg.s2y);
        st2_next.b = PROD_W'(st1_reg.s2x) * PROD_W'(st1_reg.s1y);
        st2_next.c = PROD_W'(st1_reg.s1x) * PROD_W'(st1_reg.dy);
        st2_next.d = PROD_W'(st1_reg.s1y) * PROD_W'(st1_reg.dx);
        st2_next.e = PROD_W'(st1_reg.s2x) * PROD_W'(st1_reg.dy);
        st2_next.f = PROD_W'(st1_reg.s2y) * PROD_W'(st1_reg.dx);
    end

    // Stage 3: denominator and parameter numerators.
    always_comb begin
        st3_next.mode   = st2_reg.mode;
        st3_next.shared = st2_reg.shared;
        st3_next.p0x    = st2_reg.p0x;
        st3_next.p0y    = st2_reg.p0y;
        st3_next.s1x    = st2_reg.s1x;
        st3_next.s1y    = st2_reg.s1y;
        st3_next.den    = CROSS_W'(st2_reg.a) - CROSS_W'(st2_reg.b);
        st3_next.snum   = CROSS_W'(st2_reg.c) - CROSS_W'(st2_reg.d);
        st3_next.tnum   = CROSS_W'(st2_reg.e) - CROSS_W'(st2_reg.f);
    end

    // Stage 4: classification, result signs and magnitudes.
    cross_t dpos, spos, tpos;
    always_comb begin
        dpos = st3_reg.den[CROSS_W-1] ? -st3_reg.den  : st3_reg.den;
        spos = st3_reg.den[CROSS_W-1] ? -st3_reg.snum : st3_reg.snum;
        tpos = st3_reg.den[CROSS_W-1] ? -st3_reg.tnum : st3_reg.tnum;
        if (st3_reg.shared) begin
            st4_next.status = ST_SHARED;
        end else if (st3_reg.den == '0) begin
            st4_next.status = ST_PARALLEL;
        end else if ((st3_reg.mode == MODE_SEG || st3_reg.mode == MODE_SHARED) &&
                     (spos < 0 || spos > dpos || tpos < 0 || tpos > dpos)) begin
            st4_next.status = ST_OUTSIDE;
        end else begin
            st4_next.status = ST_HIT;
        end
        st4_next.p0x   = st3_reg.p0x;
        st4_next.p0y   = st3_reg.p0y;
        st4_next.neg_x = st3_reg.tnum[CROSS_W-1] ^ st3_reg.s1x[DIFF_W-1] ^
                         st3_reg.den[CROSS_W-1];
        st4_next.neg_y = st3_reg.tnum[CROSS_W-1] ^ st3_reg.s1y[DIFF_W-1] ^
                         st3_reg.den[CROSS_W-1];
        st4_next.ud    = MAG_W'(unsigned'(dpos));
        st4_next.tmag  = MAG_W'(unsigned'(st3_reg.tnum[CROSS_W-1] ?
                                          -st3_reg.tnum : st3_reg.tnum));
        st4_next.mx    = unsigned'(st3_reg.s1x[DIFF_W-1] ? -st3_reg.s1x : st3_reg.s1x);
        st4_next.my    = unsigned'(st3_reg.s1y[DIFF_W-1] ? -st3_reg.s1y : st3_reg.s1y);
    end

    // Stage 5: unsigned numerator products.
    always_comb begin
        st5_next.status = st4_reg.status;
        st5_next.p0x    = st4_reg.p0x;
        st5_next.p0y    = st4_reg.p0y;
        st5_next.neg_x  = st4_reg.neg_x;
        st5_next.neg_y  = st4_reg.neg_y;
        st5_next.ud     = st4_reg.ud;
        st5_next.nx     = NUM_W'(st4_reg.tmag) * NUM_W'(st4_reg.mx);
        st5_next.ny     = NUM_W'(st4_reg.tmag) * NUM_W'(st4_reg.my);
    end

    // Stage 6: scale and add half the divisor for round to nearest.
    always_comb begin
        st6_next.rem_x  = (REM_W'(st5_reg.nx) << (FRAC_BITS + 1)) + REM_W'(st5_reg.ud);
        st6_next.rem_y  = (REM_W'(st5_reg.ny) << (FRAC_BITS + 1)) + REM_W'(st5_reg.ud);
        st6_next.dvs    = {st5_reg.ud, 1'b0};
        st6_next.quo_x  = '0;
        st6_next.quo_y  = '0;
        st6_next.neg_x  = st5_reg.neg_x;
        st6_next.neg_y  = st5_reg.neg_y;
        st6_next.base_x = st5_reg.p0x;
        st6_next.base_y = st5_reg.p0y;
        st6_next.status = st5_reg.status;
    end

    // Front pipeline handshake chain.
    assign rdy[7] = div_ready;
    genvar k;
    generate
        for (k = 1; k <= 6; k++) begin : g_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) v_reg[1] <= s_tvalid;
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
            if (rdy[5]) v_reg[5] <= v_reg[4];
            if (rdy[6]) v_reg[6] <= v_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) st1_reg <= st1_next;
        if (rdy[2]) st2_reg <= st2_next;
        if (rdy[3]) st3_reg <= st3_next;
        if (rdy[4]) st4_reg <= st4_next;
        if (rdy[5]) st5_reg <= st5_next;
        if (rdy[6]) st6_reg <= st6_next;
    end

    assign s_tready = rdy[1];

    sip_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_reg[6]),
        .in_ready  (div_ready),
        .in_data   (st6_reg),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .out_data  (div_out)
    );

    // Final stage: apply sign, add the start point, saturate.
    sum_t qx, qy, vx, vy;
    logic [HIT_BITS-1:0] hx, hy;
    logic sat_x, sat_y;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic [3:0]  m_tuser_reg, m_tuser_next;
    status_t     st_fin;

    always_comb begin
        qx = sum_t'({1'b0, div_out.quo_x[QB_W-1:0]});
        qy = sum_t'({1'b0, div_out.quo_y[QB_W-1:0]});
        vx = (div_out.neg_x ? -qx : qx) + (sum_t'(div_out.base_x) <<< FRAC_BITS);
        vy = (div_out.neg_y ? -qy : qy) + (sum_t'(div_out.base_y) <<< FRAC_BITS);
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (div_out.quo_x[QB_W]) begin
            hx = div_out.neg_x ? HIT_BITS'(LO_LIM) : HIT_BITS'(HI_LIM);
        end else if (vx > HI_LIM) begin
            hx = HIT_BITS'(HI_LIM);
        end else if (vx < LO_LIM) begin
            hx = HIT_BITS'(LO_LIM);
        end else begin
            hx = HIT_BITS'(vx);
            sat_x = 1'b0;
        end
        if (div_out.quo_y[QB_W]) begin
            hy = div_out.neg_y ? HIT_BITS'(LO_LIM) : HIT_BITS'(HI_LIM);
        end else if (vy > HI_LIM) begin
            hy = HIT_BITS'(HI_LIM);
        end else if (vy < LO_LIM) begin
            hy = HIT_BITS'(LO_LIM);
        end else begin
            hy = HIT_BITS'(vy);
            sat_y = 1'b0;
        end
        st_fin = div_out.status;
        if (div_out.status == ST_HIT) begin
            if (sat_x || sat_y) st_fin = ST_SAT;
            m_tdata_next = {hy, hx};
            m_tuser_next = {st_fin, 1'b1};
        end else begin
            m_tdata_next = '0;
            m_tuser_next = {st_fin, 1'b0};
        end
    end

    // Output register.
    assign out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/sip_div.sv -----
// ---------------------------------------------------------------------------
// Segment intersection divider
// Restoring division of both coordinate numerators by the shared divisor,
// one quotient bit per pipeline stage, with elastic per-stage handshakes.
// ---------------------------------------------------------------------------
module sip_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sip_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sip_pkg::div_t out_data
);
    import sip_pkg::*;

    localparam int NST = QB_W + 1;

    div_t          st_reg [NST];
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;
    div_t          st_next [NST];

    assign rdy[NST] = out_ready;

    genvar j;
    generate
        for (j = 0; j < NST; j++) begin : g_stage
            localparam int BIT = QB_W - j;
            div_t src;
            logic [REM_W-1:0] sh;

            // A stage may load when empty or when its content moves on.
            assign rdy[j] = !v_reg[j] || rdy[j+1];

            if (j == 0) begin : g_first
                assign src = in_data;
            end else begin : g_rest
                assign src = st_reg[j-1];
            end

            assign sh = REM_W'(src.dvs) << BIT;

            // Trial subtract of the divisor at this bit weight, both coordinates.
            always_comb begin
                st_next[j] = src;
                if (src.rem_x >= sh) begin
                    st_next[j].rem_x      = src.rem_x - sh;
                    st_next[j].quo_x[BIT] = 1'b1;
                end
                if (src.rem_y >= sh) begin
                    st_next[j].rem_y      = src.rem_y - sh;
                    st_next[j].quo_y[BIT] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (rdy[j]) begin
                    v_reg[j] <= (j == 0) ? in_valid : v_reg[(j == 0) ? 0 : j-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[j]) begin
                    st_reg[j] <= st_next[j];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

// ----- verif/tb_segment_intersection_point.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segment intersection point testbench
// Streams segment pairs through the block, predicts each crossing result
// with exact wide integer arithmetic, and compares every result transaction
// in order. Both stream sides idle at random, and the result side is held
// off for a long stretch so that the pipeline fills and stalls its input.
// ---------------------------------------------------------------------------
module tb_segment_intersection_point;
    import sip_pkg::*;

    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint     QUOT_LIMIT = 64'sd1 << 60;
    localparam longint     HIT_MAX    = (64'sd1 <<< (HIT_BITS - 1)) - 1;
    localparam longint     HIT_MIN    = -(64'sd1 <<< (HIT_BITS - 1));

    typedef struct {
        logic [1:0] mode;
        coord_t     pt[8];  // x0 y0 x1 y1 x2 y2 x3 y3
    } seg_query_t;

    typedef struct {
        logic                       hit;
        status_t                    status;
        logic signed [HIT_BITS-1:0] hx;
        logic signed [HIT_BITS-1:0] hy;
    } crossing_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [3:0]   m_tuser;

    crossing_t crossings_due[$];
    int        error_count;
    int        status_seen[8];
    int        rx_hold_request;
    bit        tx_burst;

    segment_intersection_point uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // base*2^F + round(t_num*delta*2^F/den), ties away from zero, saturated.
    function automatic longint scale_coord(longint base, longint tnum, longint delta,
                                           longint den, inout bit sat);
        logic [127:0] num;
        logic [127:0] quo;
        longint       v;
        bit           neg;
        neg = ((tnum < 0) != (delta < 0)) != (den < 0);
        num = 128'(magnitude(tnum)) * 128'(magnitude(delta));
        num = (num << (FRAC_BITS + 1)) + 128'(magnitude(den));
        quo = num / (128'(magnitude(den)) * 2);
        if (quo >= 128'(QUOT_LIMIT)) begin
            sat = 1'b1;
            quo = 128'(QUOT_LIMIT);
        end
        v = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        v = v + base * (64'sd1 <<< FRAC_BITS);
        if (v > HIT_MAX) begin
            v = HIT_MAX;
            sat = 1'b1;
        end
        if (v < HIT_MIN) begin
            v = HIT_MIN;
            sat = 1'b1;
        end
        return v;
    endfunction

    function automatic crossing_t predict_crossing(seg_query_t q);
        crossing_t r;
        longint    p[8];
        longint    s1x, s1y, s2x, s2y, dx, dy, den, snum, tnum, d, sn, tn;
        bit        sat;
        bit        shared;
        for (int i = 0; i < 8; i++)
            p[i] = longint'(q.pt[i]);
        s1x  = p[2] - p[0];
        s1y  = p[3] - p[1];
        s2x  = p[6] - p[4];
        s2y  = p[7] - p[5];
        dx   = p[0] - p[4];
        dy   = p[1] - p[5];
        den  = s1x * s2y - s2x * s1y;
        snum = s1x * dy - s1y * dx;
        tnum = s2x * dy - s2y * dx;
        sat  = 1'b0;
        r.status = ST_HIT;
        r.hx = '0;
        r.hy = '0;
        shared = (p[0] == p[4] && p[1] == p[5]) || (p[2] == p[6] && p[3] == p[7]) ||
                 (p[0] == p[6] && p[1] == p[7]) || (p[4] == p[2] && p[5] == p[3]);
        if (q.mode == MODE_SHARED && shared) begin
            r.status = ST_SHARED;
        end else if (den == 0) begin
            r.status = ST_PARALLEL;
        end else begin
            // Segment bounds without division: flip signs so den is positive.
            if (q.mode == MODE_SEG || q.mode == MODE_SHARED) begin
                d  = den;
                sn = snum;
                tn = tnum;
                if (d < 0) begin
                    d  = -d;
                    sn = -sn;
                    tn = -tn;
                end
                if (sn < 0 || sn > d || tn < 0 || tn > d)
                    r.status = ST_OUTSIDE;
            end
            if (r.status == ST_HIT) begin
                r.hx = HIT_BITS'(scale_coord(p[0], tnum, s1x, den, sat));
                r.hy = HIT_BITS'(scale_coord(p[1], tnum, s1y, den, sat));
                if (sat)
                    r.status = ST_SAT;
            end
        end
        r.hit = (r.status == ST_HIT || r.status == ST_SAT);
        return r;
    endfunction

    // Offer one query and wait for its transaction; the caller is at an edge.
    task automatic send_query(seg_query_t q);
        int           gap;
        logic [127:0] word;
        for (int i = 0; i < 8; i++)
            word[16*i +: 16] = q.pt[i];
        s_tvalid <= 1'b1;
        s_tuser  <= q.mode;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        crossings_due.push_back(predict_crossing(q));
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_points(logic [1:0] mode, coord_t x0, coord_t y0, coord_t x1,
                               coord_t y1, coord_t x2, coord_t y2, coord_t x3, coord_t y3);
        seg_query_t q;
        q.mode = mode;
        q.pt   = '{x0, y0, x1, y1, x2, y2, x3, y3};
        send_query(q);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (crossings_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Random coordinate: narrow range for frequent hits, full range, or an extreme.
    function automatic coord_t rand_coord(int spread);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return (roll < 2) ? coord_t'(16'h8000) : coord_t'(16'h7fff);
        if (spread == 0)
            return coord_t'($urandom_range(128) - 64);
        return coord_t'($urandom());
    endfunction

    function automatic seg_query_t rand_query(logic [1:0] mode);
        seg_query_t q;
        int         spread;
        int         shape;
        int         k;
        q.mode = mode;
        spread = ($urandom_range(3) == 0) ? 1 : 0;
        for (int i = 0; i < 8; i++)
            q.pt[i] = rand_coord(spread);
        shape = $urandom_range(9);
        if (shape == 0) begin
            // Parallel: second direction is a multiple of the first.
            k = $urandom_range(3) - 1;
            q.pt[6] = q.pt[4] + coord_t'(k * (q.pt[2] - q.pt[0]));
            q.pt[7] = q.pt[5] + coord_t'(k * (q.pt[3] - q.pt[1]));
        end else if (shape == 1) begin
            // Shared endpoint, one of the four pairings.
            k = $urandom_range(3);
            case (k)
                0: begin
                    q.pt[4] = q.pt[0];
                    q.pt[5] = q.pt[1];
                end
                1: begin
                    q.pt[6] = q.pt[2];
                    q.pt[7] = q.pt[3];
                end
                2: begin
                    q.pt[6] = q.pt[0];
                    q.pt[7] = q.pt[1];
                end
                default: begin
                    q.pt[4] = q.pt[2];
                    q.pt[5] = q.pt[3];
                end
            endcase
        end else if (shape == 2) begin
            // Nearly parallel long lines push the point out of range.
            q.pt[6] = q.pt[4] + (q.pt[2] - q.pt[0]);
            q.pt[7] = q.pt[5] + (q.pt[3] - q.pt[1]) + coord_t'($urandom_range(2) - 1);
        end
        return q;
    endfunction

    task automatic test_directed();
        // Crossing X, touching at bounds, and the shared endpoint pairings.
        send_points(MODE_SEG, -10, -10, 10, 10, -10, 10, 10, -10);
        send_points(MODE_SEG, 0, 0, 10, 0, 0, -5, 0, 5);
        send_points(MODE_SEG, 0, 0, 10, 0, 10, -5, 10, 5);
        send_points(MODE_SEG, 0, 0, 3, 0, 1, -1, 2, 2);
        send_points(MODE_SEG, 0, 0, 10, 0, 11, -5, 11, 5);
        send_points(MODE_SHARED, 0, 0, 10, 10, 0, 0, 10, -3);
        send_points(MODE_SHARED, 0, 0, 10, 10, 5, -3, 10, 10);
        send_points(MODE_SHARED, 0, 0, 10, 10, 5, -3, 0, 0);
        send_points(MODE_SHARED, 0, 0, 10, 10, 10, 10, 5, -3);
        send_points(MODE_SHARED, -10, -10, 10, 10, -10, 10, 10, -10);
        // Parallel, collinear, and a degenerate zero-length segment.
        send_points(MODE_SEG, 0, 0, 10, 0, 0, 1, 10, 1);
        send_points(MODE_LINE, 0, 0, 10, 0, 20, 0, 30, 0);
        send_points(MODE_SEG, 4, 4, 4, 4, 0, 0, 9, 9);
        // Lines meeting far outside the segments, and the spare mode.
        send_points(MODE_LINE, 0, 0, 1, 0, 1000, 3, 1000, 5);
        send_points(MODE_SPARE, 0, 0, 1, 1, 0, 3, 1, 2);
        send_points(MODE_SEG, 0, 0, 1, 1, 0, 3, 1, 2);
        // Coordinate extremes and saturation.
        send_points(MODE_SEG, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_points(MODE_LINE, -32768, -32768, 32767, -32767, -32768, -32767, 32767, -32766);
        send_points(MODE_LINE, 32767, 32767, 32767, 32766, -32768, 0, -32767, 0);
        send_points(MODE_LINE, -32768, 32767, -32767, 32767, 0, -32768, 0, -32767);
        send_points(MODE_SEG, 32767, 0, -32768, 0, 0, 32767, 0, -32768);
        send_points(MODE_LINE, 0, 0, 1, 3, 0, 1, 3, 9);
        wait_drained();
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
            send_query(rand_query(2'($urandom_range(3))));
    endtask

    // Results held off while the sender keeps offering back to back.
    task automatic test_result_backpressure();
        rx_hold_request = 300;
        tx_burst = 1'b1;
        for (int i = 0; i < 120; i++)
            send_query(rand_query(2'($urandom_range(3))));
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // Result side ready: random stalls, with held stretches on request.
    initial begin
        int hold_left;
        int roll;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request > 0) begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                roll = pick_gap();
                if (roll > 0) begin
                    hold_left = roll - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        crossing_t exp_r;
        crossing_t act_r;
        if (aresetn && m_tvalid && m_tready) begin
            act_r.hx     = m_tdata[23:0];
            act_r.hy     = m_tdata[47:24];
            act_r.hit    = m_tuser[0];
            act_r.status = status_t'(m_tuser[3:1]);
            if (crossings_due.size() == 0) begin
                $display("%0t: unexpected result hit=%0d status=%0d x=%0d y=%0d", $time,
                         act_r.hit, act_r.status, act_r.hx, act_r.hy);
                error_count++;
            end else begin
                exp_r = crossings_due.pop_front();
                status_seen[act_r.status]++;
                if (act_r.hit !== exp_r.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, act_r.hit);
                    error_count++;
                end
                if (act_r.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, act_r.status);
                    error_count++;
                end
                if (act_r.hx !== exp_r.hx) begin
                    $display("%0t: hit_x expected %0d actual %0d", $time, exp_r.hx, act_r.hx);
                    error_count++;
                end
                if (act_r.hy !== exp_r.hy) begin
                    $display("%0t: hit_y expected %0d actual %0d", $time, exp_r.hy, act_r.hy);
                    error_count++;
                end
            end
        end
    end

    // Hard limit on run length.
    initial begin
        #20ms;
        $display("tb_segment_intersection_point: done, errors");
        $finish;
    end

    initial begin
        error_count = 0;
        rx_hold_request = 0;
        tx_burst = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix(900);
        test_result_backpressure();
        test_random_mix(900);
        wait_drained();

        $display("Covered all modes: hits %0d, parallel %0d, outside %0d,",
                 status_seen[ST_HIT], status_seen[ST_PARALLEL], status_seen[ST_OUTSIDE]);
        $display("shared endpoint %0d, saturated %0d, with a long result stall.",
                 status_seen[ST_SHARED], status_seen[ST_SAT]);
        if (error_count == 0 && crossings_due.size() == 0)
            $display("tb_segment_intersection_point: done, clean");
        else
            $display("tb_segment_intersection_point: done, errors");
        $finish;
    end

endmodule
